// ----- sv/wtf8_pkg.sv -----
package wtf8_pkg;

   localparam logic [7:0]  ContMask  = 8'hC0;
   localparam logic [7:0]  ContTag   = 8'h80;
   localparam logic [7:0]  FirstLead = 8'hC2;
   localparam logic [7:0]  LastLead2 = 8'hDF;
   localparam logic [7:0]  LastLead3 = 8'hEF;
   localparam logic [7:0]  LastLead4 = 8'hF4;
   localparam logic [20:0] PointMask = 21'h1FFFFF;
   localparam logic [20:0] MaxPoint  = 21'h10FFFF;
   localparam logic [20:0] Plane1    = 21'h010000;
   localparam logic [15:0] HiSurr    = 16'hD800;
   localparam logic [15:0] LoSurr    = 16'hDC00;
   localparam logic [15:0] ErrUnit   = 16'hFFFF;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        bad_sequence;
      logic        string_end;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

endpackage

// ----- sv/wtf8_decode.sv -----
module wtf8_decode
   import wtf8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] byte_in,
   output decode_type decode
);

   logic [1:0]  pending_ff, pending_in;
   logic [20:0] point_ff, point_in;
   logic [7:0]  lead_ff, lead_in;

   logic [20:0] shifted;
   logic [20:0] cp;
   logic [20:0] offset;
   logic        emit_point;

   function automatic result_type make_result(input logic [15:0] unit, input logic bad,
                                              input logic fin, input logic last);
      result_type r;
      r.code_unit    = unit;
      r.bad_sequence = bad;
      r.string_end   = fin;
      r.last_of_run  = last;
      return r;
   endfunction

   always_comb begin
      pending_in = pending_ff;
      point_in   = point_ff;
      lead_in    = lead_ff;
      emit_point = 1'b0;
      cp         = '0;
      shifted    = {point_ff[14:0], 6'(byte_in[5:0])} & PointMask;
      offset     = '0;
      decode.count  = 2'd0;
      decode.first  = make_result(ErrUnit, 1'b1, 1'b0, 1'b1);
      decode.second = make_result(ErrUnit, 1'b1, 1'b0, 1'b1);

      if (pending_ff == 2'd0) begin
         if (byte_in == 8'h00) begin
            decode.count = 2'd1;
            decode.first = make_result(16'h0000, 1'b0, 1'b1, 1'b1);
         end else if (byte_in <= 8'h7F) begin
            decode.count = 2'd1;
            decode.first = make_result({8'h00, byte_in}, 1'b0, 1'b0, 1'b1);
         end else if (byte_in < FirstLead) begin
            decode.count = 2'd1;
         end else begin
            lead_in  = byte_in;
            point_in = {13'd0, byte_in};
            if (byte_in <= LastLead2) begin
               pending_in = 2'd1;
            end else if (byte_in <= LastLead3) begin
               pending_in = 2'd2;
            end else begin
               pending_in = 2'd3;
            end
         end
      end else if (byte_in == 8'h00) begin
         pending_in   = 2'd0;
         decode.count = 2'd1;
         decode.first = make_result(ErrUnit, 1'b1, 1'b1, 1'b1);
      end else if ((byte_in & ContMask) != ContTag) begin
         pending_in   = 2'd0;
         decode.count = 2'd1;
      end else begin
         point_in   = shifted;
         pending_in = pending_ff - 2'd1;
         if (pending_ff == 2'd1) begin
            if (lead_ff <= LastLead2) begin
               cp         = {10'd0, shifted[10:0]};
               emit_point = 1'b1;
            end else if (lead_ff <= LastLead3) begin
               cp         = {5'd0, shifted[15:0]};
               emit_point = 1'b1;
            end else if (lead_ff <= LastLead4 && shifted <= MaxPoint) begin
               cp         = shifted;
               emit_point = 1'b1;
            end else begin
               decode.count = 2'd1;
            end
         end
      end

      if (emit_point) begin
         if (cp > 21'h00FFFF) begin
            offset        = cp - Plane1;
            decode.count  = 2'd2;
            decode.first  = make_result(HiSurr + {6'd0, offset[19:10]}, 1'b0, 1'b0, 1'b0);
            decode.second = make_result(LoSurr + {6'd0, offset[9:0]}, 1'b0, 1'b0, 1'b1);
         end else begin
            decode.count = 2'd1;
            decode.first = make_result(cp[15:0], 1'b0, 1'b0, 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         point_ff   <= '0;
         lead_ff    <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         point_ff   <= point_in;
         lead_ff    <= lead_in;
      end
   end

endmodule

// ----- sv/wtf8_to_utf16_transcoder_core.sv -----
// WTF-8 to UTF-16 transcoder.
// Request channel (req_valid/req_ready/req_byte_in) takes one byte of a
// zero-terminated WTF-8 string per handshake. Response channel
// (rsp_valid/rsp_ready/rsp_*) gives UTF-16 code units, with bad_sequence
// on malformed input (unit 0xFFFF), string_end on the terminating result
// and last_of_run on the final result caused by a request.
// Each request is decoded in the cycle it is accepted and its results land
// in a two-entry result buffer: the first result is visible in the cycle
// after acceptance. A byte that only extends a sequence gives no result.
// Throughput is one request per cycle while rsp_ready is high; a code point
// above 0xFFFF gives a surrogate pair, which stalls requests until one drains.
// req_ready is high while the buffer is empty, or holds one result that is
// being taken in the same cycle. When the receiver stalls, results hold and
// the buffer holds the results of at most one request.
// Synchronous reset empties the buffer and returns the decoder to waiting
// for a lead byte.
module wtf8_to_utf16_transcoder_core
   import wtf8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_bad_sequence,
   output logic        rsp_string_end,
   output logic        rsp_last_of_run
);

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   decode_type decode;
   logic       accept;
   logic       pop;

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign accept    = req_valid && req_ready;

   wtf8_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .byte_in (req_byte_in),
      .decode  (decode)
   );

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (accept) begin
         count_in = decode.count;
         slot0_in = decode.first;
         slot1_in = decode.second;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_code_unit    = slot0_ff.code_unit;
   assign rsp_bad_sequence = slot0_ff.bad_sequence;
   assign rsp_string_end   = slot0_ff.string_end;
   assign rsp_last_of_run  = slot0_ff.last_of_run;

endmodule
